// ----- hdl/crprof_pkg.sv -----
// Package for the code range cycle profiler.
// Holds the event and result transaction types and the status codes.
// Depends on nothing; every module of the block uses it.
package crprof_pkg;

  localparam int unsigned StampWidth = 64;
  localparam int unsigned CountWidth = 32;

  localparam logic [StampWidth-1:0] StampAllOnes = {StampWidth{1'b1}};
  localparam logic [CountWidth-1:0] CountAllOnes = {CountWidth{1'b1}};
  localparam logic [CountWidth-1:0] CountOne     = {{(CountWidth-1){1'b0}}, 1'b1};

  // Event kinds.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_END   = 1'b1
  } command_t;

  // Per-event status codes.
  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_START_DROPPED = 2'd1,
    ST_END_DROPPED   = 2'd2
  } status_t;

  // One input transaction.
  typedef struct packed {
    command_t              command;
    logic [StampWidth-1:0] cycle_stamp;
  } event_t;

  // One result transaction.
  typedef struct packed {
    status_t               status;
    logic [CountWidth-1:0] iterations_done;
    logic [StampWidth-1:0] last_duration;
    logic [StampWidth-1:0] total_cycles;
    logic                  total_wrapped;
    logic [StampWidth-1:0] shortest_duration;
    logic [StampWidth-1:0] shortest_start;
    logic [CountWidth-1:0] shortest_index;
    logic [StampWidth-1:0] longest_duration;
    logic [StampWidth-1:0] longest_start;
    logic [CountWidth-1:0] longest_index;
  } result_t;

endpackage

// ----- hdl/code_range_cycle_profiler.sv -----
// Top level of the code range cycle profiler.
// Registers each event, updates the region statistics and presents a result.
// Depends on crprof_pkg for the transaction types and status codes.
//
// Usage:
//   Events enter on in_valid/in_ready/in_data: a start or end command with a
//   64-bit cycle stamp. Each event yields exactly one result transaction on
//   out_valid/out_ready/out_data: a status and the statistics as they stand
//   after that event (iteration count, last duration, wrapping total with a
//   sticky wrap flag, shortest and longest duration with start and index).
//   From acceptance the event waits in the event register while the duration
//   subtract, the min/max compares and the total add are computed; when the
//   result register is free the statistics registers take the update and,
//   with the status register, form the result that raises out_valid.
//   Throughput is one event per cycle while out_ready is high; the statistics
//   update sets the rate, and the next event sees the state the previous one left.
//   When the receiver stalls, the result holds and the event register can
//   still take one more event; after that in_ready drops until out_ready.
//   Reset clears both valid flags, closes any open region and returns all
//   statistics to their idle values (shortest duration to all ones).
module code_range_cycle_profiler (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  crprof_pkg::event_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crprof_pkg::result_t out_data
);

  // Event register.
  logic               ev_valid;
  crprof_pkg::event_t ev;

  // Profiling state.
  logic                              region_open;
  logic [crprof_pkg::StampWidth-1:0] open_start;
  logic [crprof_pkg::CountWidth-1:0] count_reg;
  logic [crprof_pkg::StampWidth-1:0] sum_reg;
  logic                              sum_wrapped_reg;
  logic [crprof_pkg::StampWidth-1:0] min_reg;
  logic [crprof_pkg::StampWidth-1:0] min_start_reg;
  logic [crprof_pkg::CountWidth-1:0] min_index_reg;
  logic [crprof_pkg::StampWidth-1:0] max_reg;
  logic [crprof_pkg::StampWidth-1:0] max_start_reg;
  logic [crprof_pkg::CountWidth-1:0] max_index_reg;
  logic [crprof_pkg::StampWidth-1:0] last_reg;
  crprof_pkg::status_t               status_reg;

  // Update datapath.
  logic                              advance;
  logic                              ev_fire;
  logic                              do_open;
  logic                              do_close;
  crprof_pkg::status_t               status_next;
  logic [crprof_pkg::StampWidth-1:0] duration;
  logic [crprof_pkg::CountWidth-1:0] count_next;
  logic [crprof_pkg::StampWidth:0]   sum_ext;

  // Handshake: the result register frees when empty or taken.
  assign advance  = !out_valid || out_ready;
  assign ev_fire  = ev_valid && advance;
  assign in_ready = !ev_valid || advance;

  // Event register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      ev <= in_data;
    end
  end

  // Decode the event against the open flag.
  always_comb begin
    do_open     = 1'b0;
    do_close    = 1'b0;
    status_next = crprof_pkg::ST_OK;
    unique case (ev.command)
      crprof_pkg::CMD_START: begin
        if (region_open) begin
          status_next = crprof_pkg::ST_START_DROPPED;
        end else begin
          do_open = 1'b1;
        end
      end
      crprof_pkg::CMD_END: begin
        if (region_open) begin
          do_close = 1'b1;
        end else begin
          status_next = crprof_pkg::ST_END_DROPPED;
        end
      end
      default: status_next = crprof_pkg::ST_OK;
    endcase
  end

  // Duration modulo 2^64, saturating count and wrapping total with carry.
  assign duration   = ev.cycle_stamp - open_start;
  assign count_next = (count_reg == crprof_pkg::CountAllOnes) ? count_reg
                                                              : count_reg + crprof_pkg::CountOne;
  assign sum_ext    = {1'b0, sum_reg} + {1'b0, duration};

  // Statistics and status registers, written once per processed event.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      status_reg      <= crprof_pkg::ST_OK;
      region_open     <= 1'b0;
      open_start      <= '0;
      count_reg       <= '0;
      sum_reg         <= '0;
      sum_wrapped_reg <= 1'b0;
      min_reg         <= crprof_pkg::StampAllOnes;
      min_start_reg   <= '0;
      min_index_reg   <= '0;
      max_reg         <= '0;
      max_start_reg   <= '0;
      max_index_reg   <= '0;
      last_reg        <= '0;
    end else if (advance) begin
      out_valid <= ev_valid;
      if (ev_fire) begin
        status_reg <= status_next;
        if (do_open) begin
          region_open <= 1'b1;
          open_start  <= ev.cycle_stamp;
        end
        if (do_close) begin
          region_open <= 1'b0;
          count_reg   <= count_next;
          last_reg    <= duration;
          sum_reg     <= sum_ext[crprof_pkg::StampWidth-1:0];
          if (sum_ext[crprof_pkg::StampWidth]) begin
            sum_wrapped_reg <= 1'b1;
          end
          if (duration < min_reg) begin
            min_reg       <= duration;
            min_start_reg <= open_start;
            min_index_reg <= count_next;
          end
          if (duration > max_reg) begin
            max_reg       <= duration;
            max_start_reg <= open_start;
            max_index_reg <= count_next;
          end
        end
      end
    end
  end

  // The result is read straight from the state; it only moves on advance.
  always_comb begin
    out_data.status            = status_reg;
    out_data.iterations_done   = count_reg;
    out_data.last_duration     = last_reg;
    out_data.total_cycles      = sum_reg;
    out_data.total_wrapped     = sum_wrapped_reg;
    out_data.shortest_duration = min_reg;
    out_data.shortest_start    = min_start_reg;
    out_data.shortest_index    = min_index_reg;
    out_data.longest_duration  = max_reg;
    out_data.longest_start     = max_start_reg;
    out_data.longest_index     = max_index_reg;
  end

`ifndef SYNTHESIS
  // A receiver that takes every result never stalls the input side.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // Once an iteration has closed, the shortest never exceeds the longest.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (count_reg != '0) |-> (min_reg <= max_reg))
    else $error("shortest duration above longest duration");

  // The wrap flag is sticky.
  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    sum_wrapped_reg |=> sum_wrapped_reg)
    else $error("total wrap flag cleared");

  // A dropped event leaves the iteration count unchanged.
  a_drop_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (ev_fire && (status_next != crprof_pkg::ST_OK)) |=> $stable(count_reg))
    else $error("dropped event changed the iteration count");
`endif

endmodule
